// ----- sv/rsbk_pkg.sv -----
// ----------------------------------------------------------------------------
// rsbk_pkg
// Shared types, sizes and the key function of the record sorter.
// ----------------------------------------------------------------------------
package rsbk_pkg;

    localparam int MAX_RECORDS = 32;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int KEY_W       = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam int SALARY_W = 25;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int TAG_W    = 8;

    // Register indexes of the configuration port
    localparam logic REG_SORT_KEY = 1'b0;

    // Sort key selection
    localparam logic KEY_SALARY = 1'b0;
    localparam logic KEY_DATE   = 1'b1;

    typedef struct packed {
        logic [SALARY_W-1:0] salary;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [TAG_W-1:0]    tag;
    } t_rec;

    // One request as it travels from the front to the back
    typedef struct packed {
        t_rec rec;
        logic keep;   // room left for it in the store
        logic last;   // closes the set
    } t_qent;

    // Date compares as year, then month, then day
    function automatic logic [KEY_W-1:0] rec_key(input t_rec r, input logic by);
        logic [KEY_W-1:0] k;
        if (by == KEY_DATE) begin
            k = {2'b00, r.year, r.month, r.day};
        end else begin
            k = r.salary;
        end
        return k;
    endfunction

endpackage

// ----- sv/rsbk_in_if.sv -----
// ----------------------------------------------------------------------------
// rsbk_in_if
// Input channel: one employee record per request.
// ----------------------------------------------------------------------------
interface rsbk_in_if;
    logic        valid;
    logic        ready;
    logic [24:0] salary_cents;
    logic [4:0]  birth_day;
    logic [3:0]  birth_month;
    logic [13:0] birth_year;
    logic [7:0]  record_tag;
    logic        last_record;

    modport source (
        output valid, salary_cents, birth_day, birth_month, birth_year,
               record_tag, last_record,
        input  ready
    );
    modport sink (
        input  valid, salary_cents, birth_day, birth_month, birth_year,
               record_tag, last_record,
        output ready
    );
endinterface

// ----- sv/rsbk_out_if.sv -----
// ----------------------------------------------------------------------------
// rsbk_out_if
// Output channel: one sorted record per request.
// ----------------------------------------------------------------------------
interface rsbk_out_if;
    logic        valid;
    logic        ready;
    logic [24:0] out_salary_cents;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [7:0]  out_tag;
    logic        out_last;
    logic        overflow;

    modport source (
        output valid, out_salary_cents, out_day, out_month, out_year, out_tag,
               out_last, overflow,
        input  ready
    );
    modport sink (
        input  valid, out_salary_cents, out_day, out_month, out_year, out_tag,
               out_last, overflow,
        output ready
    );
endinterface

// ----- sv/rsbk_front.sv -----
// ----------------------------------------------------------------------------
// rsbk_front
// Accepts records and marks each as kept or dropped against the capacity.
// ----------------------------------------------------------------------------
module rsbk_front
    import rsbk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsbk_in_if.sink     i_rec,
    input  logic        i_full,
    output logic        o_push,
    output t_qent       o_ent
);

    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic             keep;

    assign i_rec.ready = !i_full;
    assign o_push      = i_rec.valid && !i_full;
    assign keep        = (r_fill < CNT_W'(MAX_RECORDS));

    always_comb begin
        o_ent.rec.salary = i_rec.salary_cents;
        o_ent.rec.day    = i_rec.birth_day;
        o_ent.rec.month  = i_rec.birth_month;
        o_ent.rec.year   = i_rec.birth_year;
        o_ent.rec.tag    = i_rec.record_tag;
        o_ent.keep       = keep;
        o_ent.last       = i_rec.last_record;
    end

    always_comb begin
        n_fill = r_fill;
        if (o_push) begin
            if (i_rec.last_record) begin
                n_fill = '0;
            end else if (keep) begin
                n_fill = r_fill + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

// ----- sv/rsbk_queue.sv -----
// ----------------------------------------------------------------------------
// rsbk_queue
// Short FIFO that decouples the front from the sort engine.
// ----------------------------------------------------------------------------
module rsbk_queue
    import rsbk_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_qent o_ent
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    t_qent            r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [OCC_W-1:0] r_occ;
    logic             do_pop;

    assign o_full  = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign o_valid = (r_occ != '0);
    assign o_ent   = r_slot[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_occ <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_occ <= r_occ + OCC_W'(1);
            end else if (!i_push && do_pop) begin
                r_occ <= r_occ - OCC_W'(1);
            end
        end
    end

endmodule

// ----- sv/rsbk_back.sv -----
// ----------------------------------------------------------------------------
// rsbk_back
// Record row: loads, sorts by odd-even transposition, then shifts out.
// ----------------------------------------------------------------------------
module rsbk_back
    import rsbk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ent_valid,
    input  t_qent       i_ent,
    output logic        o_pop,
    input  logic        i_sort_key,
    rsbk_out_if.source  o_res
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_phase;
    logic [CNT_W-1:0] n_phase;
    logic             r_ovf;
    logic             n_ovf;
    t_rec             r_row [MAX_RECORDS];
    t_rec             n_row [MAX_RECORDS];

    logic             r_out_valid;
    t_rec             r_out_rec;
    logic             r_out_last;
    logic             r_out_ovf;
    logic             take;

    assign take  = !r_out_valid || o_res.ready;
    assign o_pop = (r_state == ST_LOAD) && i_ent_valid;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_phase = r_phase;
        n_ovf   = r_ovf;
        n_row   = r_row;
        unique case (r_state)
            ST_LOAD: begin
                if (i_ent_valid) begin
                    if (i_ent.keep) begin
                        n_row[r_count[IDX_W-1:0]] = i_ent.rec;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_ent.last) begin
                        n_phase = '0;
                        n_state = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                // Swap a pair only on a strictly greater left key: keeps it stable
                for (int j = 0; j < MAX_RECORDS - 1; j++) begin
                    if ((1'(j) == r_phase[0]) && (CNT_W'(j + 1) < r_count) &&
                        (rec_key(r_row[j], i_sort_key) > rec_key(r_row[j+1], i_sort_key)))
                    begin
                        n_row[j]   = r_row[j+1];
                        n_row[j+1] = r_row[j];
                    end
                end
                n_phase = r_phase + CNT_W'(1);
                if (r_phase == r_count - CNT_W'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (take) begin
                    for (int j = 0; j < MAX_RECORDS - 1; j++) begin
                        n_row[j] = r_row[j+1];
                    end
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_phase     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_phase <= n_phase;
            r_ovf   <= n_ovf;
            if ((r_state == ST_EMIT) && take) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && take) begin
            r_out_rec  <= r_row[0];
            r_out_last <= (r_count == CNT_W'(1));
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.out_salary_cents = r_out_rec.salary;
    assign o_res.out_day          = r_out_rec.day;
    assign o_res.out_month        = r_out_rec.month;
    assign o_res.out_year         = r_out_rec.year;
    assign o_res.out_tag          = r_out_rec.tag;
    assign o_res.out_last         = r_out_last;
    assign o_res.overflow         = r_out_ovf;

endmodule

// ----- sv/record_sort_by_key.sv -----
// ----------------------------------------------------------------------------
// record_sort_by_key
// Stable sort of employee records by salary or birth date.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | carries
//  ---------+-----------+------------------+-------------------------------------
//  i_rec    | in        | valid/ready      | one record, last_record closes a set
//  o_res    | out       | valid/ready      | one sorted record, out_last, overflow
//  APB      | in        | psel/penable     | sort_key at byte address 0
//
// Records load into the row one at a time. On the closing record the row of
// MAX_RECORDS registers sorts, one odd-even transposition phase a cycle and
// one phase per record kept, then emits one record a cycle while the output
// is taken; the single shared compare row sets the pace.
// Reset is synchronous and active low; it clears all control state, the row
// itself needs none. A stalled output holds the row; the two-entry queue lets
// the front take up to two requests while the back is busy.
// ----------------------------------------------------------------------------
module record_sort_by_key
    import rsbk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsbk_in_if.sink     i_rec,
    rsbk_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic  r_sort_key;
    logic  cfg_wr;
    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    t_qent f_ent;
    t_qent q_ent;

    // Config: write completes on the access cycle, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SORT_KEY) ? {31'b0, r_sort_key} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_key <= KEY_SALARY;
        end else if (cfg_wr && (paddr[2] == REG_SORT_KEY)) begin
            r_sort_key <= pwdata[0];
        end
    end

    // Front: take requests and mark which fit in the store
    rsbk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (i_rec),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_ent   (f_ent)
    );

    // Decouple front and back
    rsbk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ent   (f_ent),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_ent)
    );

    // Back: store, sort and emit the set
    rsbk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ent_valid (q_valid),
        .i_ent       (q_ent),
        .o_pop       (q_pop),
        .i_sort_key  (r_sort_key),
        .o_res       (o_res)
    );

endmodule

// ----- tb/record_sort_by_key_checker.sv -----
// ----------------------------------------------------------------------------
// record_sort_by_key_checker
// Watches the record channels and the configuration port, predicts each
// sorted set and compares every emitted record with the predicted order.
// ----------------------------------------------------------------------------
module record_sort_by_key_checker
    import rsbk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsbk_in_if          i_rec,
    rsbk_out_if         i_res,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         REPORT_LIMIT  = 10;
    localparam logic [2:0] SORT_KEY_ADDR = 3'(4 * int'(REG_SORT_KEY));

    typedef struct packed {
        t_rec rec;
        logic last;
        logic ovf;
    } t_sorted;

    t_rec    held[MAX_RECORDS];
    int      held_count;
    logic    dropped;
    logic    key_sel;
    t_sorted sorted_due[$];
    int      fails;
    int      checked;

    // Strictly later in the chosen order: ties keep their arrival order
    function automatic bit sorts_after(t_rec a, t_rec b, logic by);
        if (by == KEY_DATE) begin
            return {a.year, a.month, a.day} > {b.year, b.month, b.day};
        end
        return a.salary > b.salary;
    endfunction

    // Stable insertion of the held set, then queue it in emission order
    function automatic void release_set();
        t_rec    order[$];
        int      pos;
        t_sorted s;
        for (int i = 0; i < held_count; i++) begin
            pos = order.size();
            while (pos > 0 && sorts_after(order[pos-1], held[i], key_sel)) begin
                pos--;
            end
            order.insert(pos, held[i]);
        end
        foreach (order[i]) begin
            s.rec  = order[i];
            s.last = (i == order.size() - 1);
            s.ovf  = dropped;
            sorted_due.push_back(s);
        end
        held_count = 0;
        dropped    = 1'b0;
    endfunction

    function automatic string describe(t_sorted s);
        return $sformatf("salary %0d date %0d-%0d-%0d tag %0d last %0b ovf %0b",
                         s.rec.salary, s.rec.year, s.rec.month, s.rec.day,
                         s.rec.tag, s.last, s.ovf);
    endfunction

    always @(posedge i_clk) begin
        t_sorted got;
        t_sorted want;
        if (!i_rst_n) begin
            held_count = 0;
            dropped    = 1'b0;
            key_sel    = KEY_SALARY;
            fails      = 0;
            checked    = 0;
            sorted_due.delete();
        end else begin
            // Check output first: a set closed at this edge cannot emit yet
            if (i_res.valid && i_res.ready) begin
                got.rec.salary = i_res.out_salary_cents;
                got.rec.day    = i_res.out_day;
                got.rec.month  = i_res.out_month;
                got.rec.year   = i_res.out_year;
                got.rec.tag    = i_res.out_tag;
                got.last       = i_res.out_last;
                got.ovf        = i_res.overflow;
                if (sorted_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: unexpected sorted record: %s", $realtime, describe(got));
                    end
                end else begin
                    want = sorted_due.pop_front();
                    checked++;
                    if (got !== want) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: mismatch, expected %s", $realtime, describe(want));
                            $display("%0t:           got      %s", $realtime, describe(got));
                        end
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == SORT_KEY_ADDR) begin
                key_sel = i_pwdata[0];
            end
            if (i_rec.valid && i_rec.ready) begin
                if (held_count < MAX_RECORDS) begin
                    held[held_count].salary = i_rec.salary_cents;
                    held[held_count].day    = i_rec.birth_day;
                    held[held_count].month  = i_rec.birth_month;
                    held[held_count].year   = i_rec.birth_year;
                    held[held_count].tag    = i_rec.record_tag;
                    held_count++;
                end else begin
                    dropped = 1'b1;
                end
                if (i_rec.last_record) begin
                    release_set();
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= sorted_due.size();
        o_checked    <= checked;
    end

endmodule

// ----- tb/record_sort_by_key_tb.sv -----
// ----------------------------------------------------------------------------
// record_sort_by_key_tb
// Drives sets of employee records through the sorter under both sort keys,
// with random idling on both channels, a long output hold-off and sets that
// overrun the store; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module record_sort_by_key_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rsbk_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 12;
    // Time for a full set to sort and emit, with a margin on top
    localparam int SETTLE_CYCLES   = 2 * MAX_RECORDS + 40;
    // No request moving for this long means the block has hung
    localparam int STALL_LIMIT     = 4000;
    localparam int LONG_HOLD       = 400;
    localparam int SEGMENTS        = 6;
    localparam int SEGMENT_RECORDS = 62;
    localparam int HOLD_SEGMENT    = 4;
    // Register index with nothing behind it: writes must be ignored
    localparam int REG_SPARE       = 1;

    // How random record contents are drawn
    typedef enum int {
        SPREAD_TIES,   // narrow values, many equal keys
        SPREAD_RAW,    // any bit pattern the fields can hold
        SPREAD_LEGAL   // real salaries and calendar dates
    } t_spread;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rsbk_in_if  rec_ch ();
    rsbk_out_if res_ch ();

    int send_idle_pct;
    int take_stall_pct;
    int hold_request;
    int quiet_cycles = 0;
    int records_sent;
    int sets_sent;
    int overflow_sets;
    int fail_count;
    int pending;
    int checked;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    record_sort_by_key i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    record_sort_by_key_checker i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec        (rec_ch),
        .i_res        (res_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Receiver: stall at random, or hold off entirely for a requested stretch
    initial begin
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= take_stall_pct);
            end
        end
    end

    // Watchdog: count cycles in which no request moves on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (rec_ch.valid && rec_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("No request moved for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_rec emp(logic [SALARY_W-1:0] salary, logic [DAY_W-1:0] day,
                                 logic [MONTH_W-1:0] month, logic [YEAR_W-1:0] year,
                                 logic [TAG_W-1:0] tag);
        t_rec r;
        r.salary = salary;
        r.day    = day;
        r.month  = month;
        r.year   = year;
        r.tag    = tag;
        return r;
    endfunction

    function automatic t_rec random_record(t_spread spread);
        t_rec r;
        r.tag = TAG_W'($urandom);
        case (spread)
            SPREAD_TIES: begin
                r.salary = SALARY_W'($urandom_range(3));
                r.day    = DAY_W'($urandom_range(2, 1));
                r.month  = MONTH_W'($urandom_range(2, 1));
                r.year   = YEAR_W'($urandom_range(1991, 1990));
            end
            SPREAD_RAW: begin
                r.salary = SALARY_W'($urandom);
                r.day    = DAY_W'($urandom);
                r.month  = MONTH_W'($urandom);
                r.year   = YEAR_W'($urandom);
            end
            default: begin
                r.salary = SALARY_W'($urandom_range(20000000));
                r.day    = DAY_W'($urandom_range(31, 1));
                r.month  = MONTH_W'($urandom_range(12, 1));
                r.year   = YEAR_W'($urandom_range(9999));
            end
        endcase
        return r;
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic push_record(t_rec r, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            rec_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rec_ch.valid        <= 1'b1;
        rec_ch.salary_cents <= r.salary;
        rec_ch.birth_day    <= r.day;
        rec_ch.birth_month  <= r.month;
        rec_ch.birth_year   <= r.year;
        rec_ch.record_tag   <= r.tag;
        rec_ch.last_record  <= last;
        do @(posedge i_clk); while (!rec_ch.ready);
        records_sent++;
    endtask

    task automatic push_set(t_rec recs[$]);
        foreach (recs[i]) begin
            push_record(recs[i], i == recs.size() - 1);
        end
        sets_sent++;
        if (recs.size() > MAX_RECORDS) begin
            overflow_sets++;
        end
    endtask

    // Drop valid, wait for every predicted record, then let the block go quiet
    task automatic settle();
        rec_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen
    task automatic write_reg(int idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_rec    batch[$];
        t_spread spread;
        int      seg_records;
        int      set_size;
        int      pick;

        // Hold every input at a known value through reset
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        rec_ch.valid        <= 1'b0;
        rec_ch.salary_cents <= '0;
        rec_ch.birth_day    <= '0;
        rec_ch.birth_month  <= '0;
        rec_ch.birth_year   <= '0;
        rec_ch.record_tag   <= '0;
        rec_ch.last_record  <= 1'b0;
        send_idle_pct  = 25;
        take_stall_pct = 47;
        hold_request   = 0;
        records_sent   = 0;
        sets_sent      = 0;
        overflow_sets  = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Salary order straight out of reset: a lone record with every
        // field at its all-ones extreme, then ties on zero and on five
        batch = '{emp(25'h1FFFFFF, 31, 15, 16383, 255)};
        push_set(batch);
        batch = '{emp(20000000, 1, 1, 2000, 1), emp(0, 31, 12, 1980, 2),
                  emp(5, 1, 1, 0, 3), emp(0, 2, 2, 1990, 4), emp(5, 3, 3, 3, 5),
                  emp(1, 0, 0, 0, 0), emp(0, 15, 6, 2024, 7)};
        push_set(batch);

        // A write to an empty register slot must leave the key on salary
        settle();
        write_reg(REG_SPARE, 32'(KEY_DATE));
        batch = '{emp(9, 1, 1, 1, 8), emp(3, 9, 9, 9, 9)};
        push_set(batch);

        // Date order: year before month before day, equal dates keep
        // arrival order, zero and out-of-calendar values compared as given
        settle();
        write_reg(int'(REG_SORT_KEY), 32'(KEY_DATE));
        batch = '{emp(100, 10, 5, 2000, 10), emp(50, 9, 5, 2000, 11),
                  emp(25, 31, 12, 1999, 12), emp(75, 31, 4, 2000, 13),
                  emp(20, 10, 5, 2000, 14), emp(0, 0, 0, 0, 15),
                  emp(7, 31, 15, 16383, 16), emp(1, 10, 5, 2000, 17)};
        push_set(batch);

        // Random sets: alternate the key per segment, swap which side idles
        // every two segments, and finish with both sides running flat out
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            case (seg / 2)
                0: begin
                    send_idle_pct  = 25;
                    take_stall_pct = 47;
                end
                1: begin
                    send_idle_pct  = 47;
                    take_stall_pct = 25;
                end
                default: begin
                    send_idle_pct  = 0;
                    take_stall_pct = 0;
                end
            endcase
            write_reg(int'(REG_SORT_KEY), 32'((seg % 2 == 0) ? KEY_SALARY : KEY_DATE));
            // Hold the output back while records keep coming, so the store
            // and the request queue fill and the input has to stall
            if (seg == HOLD_SEGMENT) begin
                hold_request = LONG_HOLD;
            end
            seg_records = 0;
            while (seg_records < SEGMENT_RECORDS) begin
                // Mostly short sets, some up to capacity, a few past it
                pick = $urandom_range(99);
                if (pick < 60) begin
                    set_size = $urandom_range(6, 1);
                end else if (pick < 90) begin
                    set_size = $urandom_range(MAX_RECORDS, 7);
                end else begin
                    set_size = $urandom_range(MAX_RECORDS + 6, MAX_RECORDS + 1);
                end
                spread = t_spread'($urandom_range(int'(SPREAD_LEGAL)));
                batch.delete();
                repeat (set_size) batch.push_back(random_record(spread));
                push_set(batch);
                seg_records += set_size;
            end
        end

        settle();
        $display("Covered %0d records in %0d sets (%0d past capacity), sorted by salary",
                 records_sent, sets_sent, overflow_sets);
        $display("and by birth date under varied idling; %0d sorted records checked.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
